[rtl/core/hhq_pkg.sv]
// ----------------------------------------------------------------------------
// hhq_pkg
// Types and constants shared by the height query block.
// ----------------------------------------------------------------------------
package hhq_pkg;

	localparam int CFG_DATA_W = 32;

	typedef enum logic [2:0] {
		CFG_MAP_SIZE     = 3'd0,
		CFG_MAX_HEIGHT   = 3'd1,
		CFG_GRID_SQUARES = 3'd2,
		CFG_OFFSET_X     = 3'd3,
		CFG_OFFSET_Z     = 3'd4
	} cfg_idx_t;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [30:0] MAP_SIZE_RST     = 31'd16777216;
	localparam logic [30:0] MAX_HEIGHT_RST   = 31'd6553600;
	localparam logic [7:0]  GRID_SQUARES_RST = 8'd255;

	typedef struct packed {
		logic [30:0]        map_size;
		logic [30:0]        max_height;
		logic [7:0]         grid_squares;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_z;
	} cfg_t;

	typedef struct packed {
		logic        is_query;
		logic        off_grid;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [7:0]  value;
		logic [30:0] lx;
		logic [30:0] lz;
	} item_t;

endpackage

[rtl/core/hhq_front.sv]
// ----------------------------------------------------------------------------
// hhq_front
// Translates query points into terrain space, flags points off the grid and passes texel writes through.
// ----------------------------------------------------------------------------
module hhq_front #(
	parameter int GRID_VERTS = 256
) (
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               kind,
	input  logic [7:0]         texel_col,
	input  logic [7:0]         texel_row,
	input  logic [7:0]         texel_value,
	input  logic signed [31:0] world_x,
	input  logic signed [31:0] world_z,
	input  hhq_pkg::cfg_t      cfg,
	input  logic               q_ready,
	output logic               q_push,
	output hhq_pkg::item_t     q_item
);
	import hhq_pkg::*;

	logic signed [32:0] lx;
	logic signed [32:0] lz;
	logic               degenerate;
	logic               x_out;
	logic               z_out;

	always_comb begin
		lx = 33'(world_x) - 33'(cfg.offset_x);
		lz = 33'(cfg.offset_z) - 33'(world_z);
		degenerate = (cfg.map_size == '0) || (cfg.grid_squares == '0) ||
			(int'(cfg.grid_squares) >= GRID_VERTS);
		x_out = lx[32] || (lx[31:0] >= {1'b0, cfg.map_size});
		z_out = lz[32] || (lz[31:0] >= {1'b0, cfg.map_size});
		q_item.is_query = (kind == KIND_QUERY);
		q_item.off_grid = degenerate || x_out || z_out;
		q_item.col      = texel_col;
		q_item.row      = texel_row;
		q_item.value    = texel_value;
		q_item.lx       = lx[30:0];
		q_item.lz       = lz[30:0];
	end

	assign req_ready = q_ready;
	assign q_push    = req_valid && q_ready;

endmodule

[rtl/core/hhq_queue.sv]
// ----------------------------------------------------------------------------
// hhq_queue
// Two-entry queue between the front end and the evaluation unit.
// ----------------------------------------------------------------------------
module hhq_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hhq_pkg::item_t push_item,
	output logic           push_ready,
	input  logic           pop,
	output logic           pop_valid,
	output hhq_pkg::item_t pop_item
);
	import hhq_pkg::*;

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/core/hhq_back.sv]
// ----------------------------------------------------------------------------
// hhq_back
// Holds the heightmap, performs texel writes and evaluates height queries.
// ----------------------------------------------------------------------------
module hhq_back #(
	parameter int GRID_VERTS = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  hhq_pkg::cfg_t  cfg,
	input  logic           q_valid,
	input  hhq_pkg::item_t q_item,
	output logic           q_pop,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output logic [30:0]    height
);
	import hhq_pkg::*;

	localparam int DEPTH = GRID_VERTS * GRID_VERTS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_PREP, ST_MAC, ST_MULLO, ST_MULHI, ST_QDIV, ST_DONE
	} state_t;

	state_t         state_q;
	logic [4:0]     cnt_q;
	logic [38:0]    tx_q;
	logic [38:0]    tz_q;
	logic [AW-1:0]  addr_q [3];
	logic [30:0]    w_q [3];
	logic [38:0]    div_q;
	logic [38:0]    acc_q;
	logic [69:0]    prod_q;
	logic           zero_q;
	logic           rsp_valid_q;
	logic [30:0]    height_q;
	logic [7:0]     mem_q [DEPTH];
	logic [7:0]     rd_q;

	logic           mem_we;
	logic [AW-1:0]  wr_addr;
	logic [31:0]    nx, nz, subx, subz;
	logic           gex, gez;
	logic [39:0]    nq, subq;
	logic           geq;
	logic [31:0]    sum;
	logic           upper;
	logic [7:0]     gx, gz, gx1, gz1;
	logic           out_free;

	function automatic logic [AW-1:0] addr_of(input logic [7:0] c, input logic [7:0] r);
		return AW'(r) * AW'(GRID_VERTS) + AW'(c);
	endfunction

	always_comb begin
		q_pop   = q_valid && (state_q == ST_IDLE);
		mem_we  = q_pop && !q_item.is_query && (int'(q_item.col) < GRID_VERTS) &&
			(int'(q_item.row) < GRID_VERTS);
		wr_addr = addr_of(q_item.col, q_item.row);
		nx   = {tx_q[38:8], tx_q[7]};
		nz   = {tz_q[38:8], tz_q[7]};
		gex  = nx >= {1'b0, cfg.map_size};
		gez  = nz >= {1'b0, cfg.map_size};
		subx = gex ? nx - {1'b0, cfg.map_size} : nx;
		subz = gez ? nz - {1'b0, cfg.map_size} : nz;
		nq   = {prod_q[69:31], prod_q[30]};
		geq  = nq >= {1'b0, div_q};
		subq = geq ? nq - {1'b0, div_q} : nq;
		gx   = tx_q[7:0];
		gz   = tz_q[7:0];
		gx1  = gx + 8'd1;
		gz1  = gz + 8'd1;
		sum  = {1'b0, tx_q[38:8]} + {1'b0, tz_q[38:8]};
		upper = sum <= {1'b0, cfg.map_size};
		out_free = !rsp_valid_q || rsp_ready;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= q_item.value;
		end
		rd_q <= mem_q[addr_q[0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.is_query) begin
						zero_q <= q_item.off_grid;
						tx_q   <= 39'(q_item.lx) * 39'(cfg.grid_squares);
						tz_q   <= 39'(q_item.lz) * 39'(cfg.grid_squares);
						cnt_q  <= '0;
						state_q <= q_item.off_grid ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					tx_q  <= {subx[30:0], tx_q[6:0], gex};
					tz_q  <= {subz[30:0], tz_q[6:0], gez};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd7) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					div_q <= {cfg.map_size, 8'd0} - 39'(cfg.map_size);
					acc_q <= '0;
					cnt_q <= '0;
					if (upper) begin
						addr_q[0] <= addr_of(gx, gz);
						addr_q[1] <= addr_of(gx1, gz);
						addr_q[2] <= addr_of(gx, gz1);
						w_q[0]    <= 31'({1'b0, cfg.map_size} - sum);
						w_q[1]    <= tx_q[38:8];
						w_q[2]    <= tz_q[38:8];
					end else begin
						addr_q[0] <= addr_of(gx1, gz1);
						addr_q[1] <= addr_of(gx, gz1);
						addr_q[2] <= addr_of(gx1, gz);
						w_q[0]    <= 31'(sum - {1'b0, cfg.map_size});
						w_q[1]    <= cfg.map_size - tx_q[38:8];
						w_q[2]    <= cfg.map_size - tz_q[38:8];
					end
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					addr_q[0] <= addr_q[1];
					addr_q[1] <= addr_q[2];
					if (cnt_q != 5'd0) begin
						acc_q  <= acc_q + 39'(rd_q) * 39'(w_q[0]);
						w_q[0] <= w_q[1];
						w_q[1] <= w_q[2];
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd3) begin
						state_q <= ST_MULLO;
					end
				end
				ST_MULLO: begin
					prod_q  <= 70'(cfg.max_height) * 70'(acc_q[19:0]);
					state_q <= ST_MULHI;
				end
				ST_MULHI: begin
					prod_q  <= prod_q + ((70'(cfg.max_height) * 70'(acc_q[38:20])) << 20);
					cnt_q   <= '0;
					state_q <= ST_QDIV;
				end
				ST_QDIV: begin
					prod_q <= {subq[38:0], prod_q[29:0], geq};
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == 5'd30) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						height_q    <= zero_q ? '0 : prod_q[30:0];
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign height    = height_q;

endmodule

[rtl/core/heightfield_height_query.sv]
// ----------------------------------------------------------------------------
// heightfield_height_query
// Terrain height lookup with barycentric interpolation on an 8-bit heightmap.
// ----------------------------------------------------------------------------
// Items arrive on the req channel (req_valid/req_ready). A texel write stores
// one heightmap byte and gives no result. A query gives one transaction on
// the rsp channel (rsp_valid/rsp_ready) carrying the height in Q15.16.
// A write is stored as the evaluation unit takes it and leaves the unit idle.
// A query passes through cell division, three texel reads from the single
// heightmap port, two partial products and a 31-step quotient; points off
// the grid skip these steps and go straight to the result.
// The front end keeps accepting into a two-entry queue while the unit works,
// until the queue is full. A result waiting in the output register does not
// stop the next item; the unit only holds a finished query while the receiver
// stalls. Reset restores the default registers; heightmap contents are
// undefined until written. Registers must be written through cfg_we only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module heightfield_height_query #(
	parameter int GRID_VERTS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               kind,
	input  logic [7:0]         texel_col,
	input  logic [7:0]         texel_row,
	input  logic [7:0]         texel_value,
	input  logic signed [31:0] world_x,
	input  logic signed [31:0] world_z,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [30:0]        height
);
	import hhq_pkg::*;

	cfg_t  cfg_q;
	logic  q_push;
	logic  q_ready;
	item_t q_in;
	logic  q_pop;
	logic  q_valid;
	item_t q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_size     <= MAP_SIZE_RST;
			cfg_q.max_height   <= MAX_HEIGHT_RST;
			cfg_q.grid_squares <= GRID_SQUARES_RST;
			cfg_q.offset_x     <= '0;
			cfg_q.offset_z     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAP_SIZE:     cfg_q.map_size     <= cfg_data[30:0];
				CFG_MAX_HEIGHT:   cfg_q.max_height   <= cfg_data[30:0];
				CFG_GRID_SQUARES: cfg_q.grid_squares <= cfg_data[7:0];
				CFG_OFFSET_X:     cfg_q.offset_x     <= cfg_data;
				CFG_OFFSET_Z:     cfg_q.offset_z     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hhq_front #(.GRID_VERTS(GRID_VERTS)) u_front (
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.kind       (kind),
		.texel_col  (texel_col),
		.texel_row  (texel_row),
		.texel_value(texel_value),
		.world_x    (world_x),
		.world_z    (world_z),
		.cfg        (cfg_q),
		.q_ready    (q_ready),
		.q_push     (q_push),
		.q_item     (q_in)
	);

	hhq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.push_ready(q_ready),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (q_out)
	);

	hhq_back #(.GRID_VERTS(GRID_VERTS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_out),
		.q_pop    (q_pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.height   (height)
	);

endmodule

[rtl/core/hhq_checker.sv]
// ----------------------------------------------------------------------------
// hhq_checker
// Port-level checks for the height query block.
// ----------------------------------------------------------------------------
module hhq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        kind,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [30:0] height
);
	import hhq_pkg::*;

	logic [3:0] pending_q;
	logic       q_acc;
	logic       r_acc;

	assign q_acc = req_valid && req_ready && (kind == KIND_QUERY);
	assign r_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (q_acc && !r_acc) begin
			pending_q <= pending_q + 4'd1;
		end else if (r_acc && !q_acc) begin
			pending_q <= pending_q - 4'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(height))
		else $error("result changed while stalled");

	a_reset: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result valid during reset");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 4'd0)
		else $error("result transaction without an outstanding query");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'd5)
		else $error("too many queries outstanding");

endmodule

bind heightfield_height_query hhq_checker u_hhq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.kind     (kind),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.height   (height)
);
